/* design/order_book_level_diff_unit_defines.svh */
// Assertion macros used by order_book_level_diff_unit.sv to check its own logic.
`ifndef ORDER_BOOK_LEVEL_DIFF_UNIT_DEFINES_SVH
`define ORDER_BOOK_LEVEL_DIFF_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define OBLD_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define OBLD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/obld_pkg.sv */
package obld_pkg;

  localparam logic [3:0] EK_TOP_ADD_ASK  = 4'd0;
  localparam logic [3:0] EK_TOP_ADD_BID  = 4'd1;
  localparam logic [3:0] EK_TOP_REM_ASK  = 4'd2;
  localparam logic [3:0] EK_TOP_REM_BID  = 4'd3;
  localparam logic [3:0] EK_DEEP_ADD_ASK = 4'd4;
  localparam logic [3:0] EK_DEEP_ADD_BID = 4'd5;
  localparam logic [3:0] EK_DEEP_REM_ASK = 4'd6;
  localparam logic [3:0] EK_DEEP_REM_BID = 4'd7;
  localparam logic [3:0] EK_IDLE         = 4'd8;

  localparam int IN_TDATA_W  = 56;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 56;

  typedef struct packed {
    logic               side;
    logic [2:0]         level;
    logic signed [31:0] price;
    logic [15:0]        count;
    logic               store;
    logic               merge;
    logic               row_end;
    logic [3:0]         add_kind;
  } obld_cmd_t;

  typedef struct packed {
    logic [3:0]  kind;
    logic [2:0]  level;
    logic [31:0] distance;
    logic [15:0] repeat_count;
  } obld_run_t;

endpackage

/* design/obld_front.sv */
module obld_front #(
  parameter int LEVELS = 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [obld_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic [obld_pkg::IN_TUSER_W-1:0]  in_tuser,
  input  logic                             in_tlast,
  output logic                             q_valid,
  output obld_pkg::obld_cmd_t              q_cmd,
  input  logic                             q_pop
);

  localparam logic [1:0] FILL_FULL = 2'd2;

  obld_pkg::obld_cmd_t cmd_in;
  obld_pkg::obld_cmd_t fifo_r [2];
  logic                wr_ptr_r, wr_ptr_nxt;
  logic                rd_ptr_r, rd_ptr_nxt;
  logic [1:0]          fill_r, fill_nxt;
  logic                push;

  always_comb begin
    cmd_in.side     = in_tuser[0];
    cmd_in.level    = in_tdata[2:0];
    cmd_in.price    = in_tdata[34:3];
    cmd_in.count    = in_tdata[50:35];
    cmd_in.store    = ({29'd0, in_tdata[2:0]} < 32'(LEVELS));
    cmd_in.merge    = cmd_in.store && !in_tuser[1];
    cmd_in.row_end  = in_tlast;
    cmd_in.add_kind = ((in_tdata[2:0] == 3'd0) ? obld_pkg::EK_TOP_ADD_ASK
                                               : obld_pkg::EK_DEEP_ADD_ASK)
                      | {3'b000, in_tuser[0]};
  end

  assign in_tready = (fill_r != FILL_FULL);
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (fill_r != 2'd0);
  assign q_cmd     = fifo_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push  ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = q_pop ? ~rd_ptr_r : rd_ptr_r;
    fill_nxt   = fill_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= cmd_in;
    end
  end

endmodule

/* design/obld_back.sv */
module obld_back #(
  parameter int LEVELS = 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             q_valid,
  input  obld_pkg::obld_cmd_t              q_cmd,
  output logic                             q_pop,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [obld_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                             out_tlast
);

  localparam int NENT   = 2 * LEVELS;
  localparam int EW     = (NENT > 1) ? $clog2(NENT) : 1;
  localparam int CW     = $clog2(LEVELS + 1);
  localparam int MDEPTH = 2 * (2 ** EW);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_READ  = 5'b00010,
    ST_CMP   = 5'b00100,
    ST_FLUSH = 5'b01000,
    ST_MARK  = 5'b10000
  } state_t;

  state_t              state_r, state_nxt;
  obld_pkg::obld_cmd_t cmd_r, cmd_nxt;
  logic [CW-1:0]       cursor_r [2];
  logic [CW-1:0]       cursor_nxt [2];
  logic [1:0]          stopped_r, stopped_nxt;
  logic [NENT-1:0]     ob_r, ob_nxt;
  logic [NENT-1:0]     nb_r, nb_nxt;
  logic                pend_valid_r, pend_valid_nxt;
  obld_pkg::obld_run_t pend_r, pend_nxt;
  logic                out_valid_r, out_valid_nxt;
  obld_pkg::obld_run_t out_run_r, out_run_nxt;
  logic                out_last_r, out_last_nxt;

  logic [47:0]         mem [MDEPTH];
  logic signed [31:0]  rd_price_r;
  logic [15:0]         rd_count_r;

  logic                wr_en;
  logic                rd_en;
  logic [EW-1:0]       q_idx;
  logic [EW-1:0]       o_idx;
  logic [CW-1:0]       cur;
  logic                cur_end;
  logic signed [32:0]  diff;
  logic [32:0]         ndiff;
  logic [3:0]          rem_kind;
  logic                out_free;

  assign q_idx    = EW'(q_cmd.level) + (q_cmd.side ? EW'(LEVELS) : EW'(0));
  assign cur      = cursor_r[cmd_r.side];
  assign o_idx    = EW'(cur) + (cmd_r.side ? EW'(LEVELS) : EW'(0));
  assign cur_end  = (cur >= CW'(LEVELS));
  assign diff     = cmd_r.side
                    ? ({rd_price_r[31], rd_price_r} - {cmd_r.price[31], cmd_r.price})
                    : ({cmd_r.price[31], cmd_r.price} - {rd_price_r[31], rd_price_r});
  assign ndiff    = -diff;
  assign rem_kind = ((cur == CW'(0)) ? obld_pkg::EK_TOP_REM_ASK : obld_pkg::EK_DEEP_REM_ASK)
                    | {3'b000, cmd_r.side};
  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    obld_pkg::obld_run_t run;
    logic                has_run;
    logic                advance;
    logic                more;

    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    cursor_nxt     = cursor_r;
    stopped_nxt    = stopped_r;
    ob_nxt         = ob_r;
    nb_nxt         = nb_r;
    pend_valid_nxt = pend_valid_r;
    pend_nxt       = pend_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_run_nxt    = out_run_r;
    out_last_nxt   = out_last_r;
    q_pop          = 1'b0;
    wr_en          = 1'b0;
    rd_en          = 1'b0;
    run            = '0;
    has_run        = 1'b0;
    advance        = 1'b0;
    more           = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop   = 1'b1;
          cmd_nxt = q_cmd;
          if (q_cmd.store) begin
            wr_en         = 1'b1;
            nb_nxt[q_idx] = ~ob_r[q_idx];
          end
          state_nxt = ST_FLUSH;
          if (q_cmd.merge && !stopped_r[q_cmd.side]) begin
            if (q_cmd.count == 16'd0) begin
              stopped_nxt[q_cmd.side] = 1'b1;
            end else begin
              state_nxt = ST_READ;
            end
          end
        end
      end
      ST_READ: begin
        if (cur_end) begin
          stopped_nxt[cmd_r.side] = 1'b1;
          state_nxt               = ST_FLUSH;
        end else begin
          rd_en     = 1'b1;
          state_nxt = ST_CMP;
        end
      end
      ST_CMP: begin
        if (rd_count_r == 16'd0) begin
          stopped_nxt[cmd_r.side] = 1'b1;
          state_nxt               = ST_FLUSH;
        end else begin
          if (diff[32]) begin
            has_run          = 1'b1;
            run.kind         = cmd_r.add_kind;
            run.level        = cmd_r.level;
            run.distance     = (cmd_r.level == 3'd0) ? ndiff[31:0] : 32'd0;
            run.repeat_count = cmd_r.count;
          end else if (diff == 33'sd0) begin
            advance = 1'b1;
            if (cmd_r.count > rd_count_r) begin
              has_run          = 1'b1;
              run.kind         = cmd_r.add_kind;
              run.level        = cmd_r.level;
              run.repeat_count = cmd_r.count - rd_count_r;
            end else if (cmd_r.count < rd_count_r) begin
              has_run          = 1'b1;
              run.kind         = rem_kind;
              run.level        = 3'(cur);
              run.repeat_count = rd_count_r - cmd_r.count;
            end
          end else begin
            has_run          = 1'b1;
            advance          = 1'b1;
            more             = 1'b1;
            run.kind         = rem_kind;
            run.level        = 3'(cur);
            run.repeat_count = rd_count_r;
          end

          if (!(has_run && pend_valid_r && !out_free)) begin
            if (has_run) begin
              if (pend_valid_r) begin
                out_valid_nxt = 1'b1;
                out_run_nxt   = pend_r;
                out_last_nxt  = 1'b0;
              end
              pend_valid_nxt = 1'b1;
              pend_nxt       = run;
            end
            if (advance) begin
              cursor_nxt[cmd_r.side] = cur + CW'(1);
            end
            state_nxt = more ? ST_READ : ST_FLUSH;
          end
        end
      end
      ST_FLUSH: begin
        if (pend_valid_r) begin
          if (out_free) begin
            out_valid_nxt  = 1'b1;
            out_run_nxt    = pend_r;
            out_last_nxt   = !cmd_r.row_end;
            pend_valid_nxt = 1'b0;
            state_nxt      = cmd_r.row_end ? ST_MARK : ST_IDLE;
          end
        end else begin
          state_nxt = cmd_r.row_end ? ST_MARK : ST_IDLE;
        end
      end
      ST_MARK: begin
        if (out_free) begin
          out_valid_nxt            = 1'b1;
          out_run_nxt.kind         = obld_pkg::EK_IDLE;
          out_run_nxt.level        = 3'd0;
          out_run_nxt.distance     = 32'd0;
          out_run_nxt.repeat_count = 16'd1;
          out_last_nxt             = 1'b1;
          ob_nxt                   = nb_r;
          cursor_nxt[0]            = CW'(0);
          cursor_nxt[1]            = CW'(0);
          stopped_nxt              = 2'b00;
          state_nxt                = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cursor_r[0]  <= CW'(0);
      cursor_r[1]  <= CW'(0);
      stopped_r    <= 2'b00;
      ob_r         <= '0;
      nb_r         <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cursor_r     <= cursor_nxt;
      stopped_r    <= stopped_nxt;
      ob_r         <= ob_nxt;
      nb_r         <= nb_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    pend_r     <= pend_nxt;
    out_run_r  <= out_run_nxt;
    out_last_r <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[{~ob_r[q_idx], q_idx}] <= {q_cmd.price, q_cmd.count};
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      {rd_price_r, rd_count_r} <= mem[{ob_r[o_idx], o_idx}];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {1'b0, out_run_r.repeat_count, out_run_r.distance,
                       out_run_r.level, out_run_r.kind};

endmodule

/* design/order_book_level_diff_unit.sv */
// Channel  Direction  Payload
// in_      slave      tdata: level, price, count; tuser: side, first_row; tlast: row_end
// out_     master     tdata: event_kind, event_level, distance, repeat_count; tlast: last
//
// An item leaves the queue, then each old level that the merge examines takes a snapshot
// memory read followed by a price compare; a further step notes a cursor that has run past
// the last level, and a final step finishes the item. A row end adds the idle marker, and a
// run waits while the output is full.
// Reset is synchronous and active low; the snapshot memory is not cleared.
// A two-entry queue accepts items while the back end works or the output stalls, until it is full.
`include "order_book_level_diff_unit_defines.svh"

module order_book_level_diff_unit #(
  parameter int LEVELS = 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // level [2:0], price [34:3], count [50:35], zero fill above
  input  logic [obld_pkg::IN_TDATA_W-1:0]  in_tdata,
  // side [0], first_row [1]
  input  logic [obld_pkg::IN_TUSER_W-1:0]  in_tuser,
  input  logic                             in_tlast,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // event_kind [3:0], event_level [6:4], distance [38:7], repeat_count [54:39], zero fill
  output logic [obld_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                             out_tlast
);

  logic                q_valid;
  logic                q_pop;
  obld_pkg::obld_cmd_t q_cmd;
  logic                idle_seen;
  logic                idle_good;

  obld_front #(
    .LEVELS(LEVELS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop)
  );

  obld_back #(
    .LEVELS(LEVELS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_cmd      (q_cmd),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  assign idle_seen = out_tvalid && (out_tdata[3:0] == obld_pkg::EK_IDLE);
  assign idle_good = out_tlast && (out_tdata[54:39] == 16'd1) && (out_tdata[38:4] == 35'd0);

  `OBLD_ASSERT_SAME(a_pop_needs_item, q_pop, q_valid, "queue popped while empty")
  `OBLD_ASSERT_SAME(a_full_has_item, !in_tready, q_valid, "input stalled with empty queue")
  `OBLD_ASSERT_NEXT(a_pop_spacing, q_pop, !q_pop, "back end took two items in a row")
  `OBLD_ASSERT_SAME(a_idle_marker, idle_seen, idle_good, "malformed idle marker")

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 100ps

module testbench;

  localparam int BOOK_LEVELS = 8;
  localparam logic signed [31:0] PRICE_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] PRICE_MIN = 32'sh8000_0000;
  localparam bit ASK = 1'b0;
  localparam bit BID = 1'b1;

  typedef struct packed {
    logic [3:0]  kind;
    logic [2:0]  level;
    logic [31:0] distance;
    logic [15:0] repeat_count;
    logic        last;
  } book_event_t;

  logic                             clk;
  logic                             rst_n = 1'b0;
  logic                             in_tvalid = 1'b0;
  logic                             in_tready;
  logic [obld_pkg::IN_TDATA_W-1:0]  in_tdata = '0;
  logic [obld_pkg::IN_TUSER_W-1:0]  in_tuser = '0;
  logic                             in_tlast = 1'b0;
  logic                             out_tvalid;
  logic                             out_tready = 1'b0;
  logic [obld_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                             out_tlast;

  order_book_level_diff_unit #(.LEVELS(BOOK_LEVELS)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  logic signed [31:0] prev_px  [2*BOOK_LEVELS];
  logic [15:0]        prev_qty [2*BOOK_LEVELS];
  logic signed [31:0] cur_px   [2*BOOK_LEVELS];
  logic [15:0]        cur_qty  [2*BOOK_LEVELS];
  int                 merge_cursor [2];
  bit                 merge_done   [2];

  book_event_t        pending_events[$];
  logic signed [31:0] book_mid = 32'sd1000;
  int                 send_idle_odds = 4;
  int                 recv_idle_odds = 4;
  int                 hold_request = 0;
  int                 long_holds = 0;
  int                 items_sent = 0;
  int                 rows_sent = 0;
  int                 results_seen = 0;
  int                 mismatches = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("order_book_level_diff_unit regression: fail");
    $finish;
  end

  function automatic book_event_t make_event(logic [3:0] kind, logic [2:0] lvl,
                                             logic [31:0] dist_ticks, logic [15:0] rep);
    book_event_t ev;
    ev.kind = kind;
    ev.level = lvl;
    ev.distance = dist_ticks;
    ev.repeat_count = rep;
    ev.last = 1'b0;
    return ev;
  endfunction

  // Merges one arriving level against the stored book and queues the runs it causes.
  function automatic void predict_events(bit side, logic [2:0] lvl, logic signed [31:0] px,
                                         logic [15:0] qty, bit fr, bit re);
    book_event_t evs[$];
    int          idx;
    int          i;
    int          old_idx;
    longint      gap;
    logic [63:0] mag;
    logic [3:0]  add_kind;
    logic [3:0]  rem_kind;
    bit          done;
    idx = side * BOOK_LEVELS + lvl;
    if (lvl == 0) begin
      add_kind = side ? obld_pkg::EK_TOP_ADD_BID : obld_pkg::EK_TOP_ADD_ASK;
    end else begin
      add_kind = side ? obld_pkg::EK_DEEP_ADD_BID : obld_pkg::EK_DEEP_ADD_ASK;
    end
    cur_px[idx] = px;
    cur_qty[idx] = qty;
    if (!fr && !merge_done[side]) begin
      if (qty == 0) begin
        merge_done[side] = 1'b1;
      end else begin
        done = 1'b0;
        while (!done) begin
          i = merge_cursor[side];
          old_idx = side * BOOK_LEVELS + i;
          if (i >= BOOK_LEVELS || prev_qty[old_idx] == 0) begin
            merge_done[side] = 1'b1;
            done = 1'b1;
          end else begin
            if (i == 0) begin
              rem_kind = side ? obld_pkg::EK_TOP_REM_BID : obld_pkg::EK_TOP_REM_ASK;
            end else begin
              rem_kind = side ? obld_pkg::EK_DEEP_REM_BID : obld_pkg::EK_DEEP_REM_ASK;
            end
            gap = side ? (longint'(prev_px[old_idx]) - longint'(px))
                       : (longint'(px) - longint'(prev_px[old_idx]));
            if (gap < 0) begin
              mag = -gap;
              evs.push_back(make_event(add_kind, lvl, (lvl == 0) ? mag[31:0] : 32'd0, qty));
              done = 1'b1;
            end else if (gap == 0) begin
              if (qty > prev_qty[old_idx]) begin
                evs.push_back(make_event(add_kind, lvl, 32'd0, qty - prev_qty[old_idx]));
              end else if (qty < prev_qty[old_idx]) begin
                evs.push_back(make_event(rem_kind, 3'(i), 32'd0, prev_qty[old_idx] - qty));
              end
              merge_cursor[side] = i + 1;
              done = 1'b1;
            end else begin
              evs.push_back(make_event(rem_kind, 3'(i), 32'd0, prev_qty[old_idx]));
              merge_cursor[side] = i + 1;
            end
          end
        end
      end
    end
    if (re) begin
      prev_px = cur_px;
      prev_qty = cur_qty;
      merge_cursor[0] = 0;
      merge_cursor[1] = 0;
      merge_done[0] = 1'b0;
      merge_done[1] = 1'b0;
      evs.push_back(make_event(obld_pkg::EK_IDLE, 3'd0, 32'd0, 16'd1));
    end
    if (evs.size() > 0) begin
      evs[evs.size()-1].last = 1'b1;
    end
    foreach (evs[k]) pending_events.push_back(evs[k]);
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("[%0t] mismatch in %s: got %0h, expected %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin : check_results
    book_event_t want;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (pending_events.size() == 0) begin
        report_mismatch("unexpected item", out_tdata[31:0], 32'd0);
      end else begin
        want = pending_events.pop_front();
        if (out_tdata[3:0] !== want.kind)
          report_mismatch("event_kind", 32'(out_tdata[3:0]), 32'(want.kind));
        if (out_tdata[6:4] !== want.level)
          report_mismatch("event_level", 32'(out_tdata[6:4]), 32'(want.level));
        if (out_tdata[38:7] !== want.distance)
          report_mismatch("distance", out_tdata[38:7], want.distance);
        if (out_tdata[54:39] !== want.repeat_count)
          report_mismatch("repeat_count", 32'(out_tdata[54:39]), 32'(want.repeat_count));
        if (out_tlast !== want.last)
          report_mismatch("last", 32'(out_tlast), 32'(want.last));
      end
    end
  end

  // The long hold is counted here so that the sender keeps offering items meanwhile.
  initial begin : drive_ready
    int held;
    while (!rst_n) @(posedge clk);
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        out_tready <= 1'b0;
        held = 0;
        while (held < hold_request) begin
          @(posedge clk);
          held++;
        end
        hold_request = 0;
        long_holds++;
        out_tready <= 1'b1;
      end else if (recv_idle_odds != 0 && $urandom_range(0, recv_idle_odds - 1) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic send_level(bit side, logic [2:0] lvl, logic signed [31:0] px,
                            logic [15:0] qty, bit fr, bit re);
    if (send_idle_odds != 0 && $urandom_range(0, send_idle_odds - 1) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {5'b0, qty, px, lvl};
    in_tuser  <= {fr, side};
    in_tlast  <= re;
    do @(posedge clk); while (!in_tready);
    predict_events(side, lvl, px, qty, fr, re);
    items_sent++;
    if (re) rows_sent++;
  endtask

  task automatic wait_drain(int settle);
    in_tvalid <= 1'b0;
    while (pending_events.size() > 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  function automatic logic [15:0] book_qty();
    case ($urandom_range(0, 15))
      0:       return 16'hFFFF;
      1:       return 16'($urandom_range(1, 65535));
      default: return 16'($urandom_range(1, 12));
    endcase
  endfunction

  // A well-formed row: asks rising, bids falling, a random depth on each side.
  task automatic send_book_row(bit fr, int n_items);
    logic signed [31:0] px;
    logic [15:0]        qty;
    int                 depth;
    int                 k;
    bit                 side;
    int                 lvl;
    book_mid = book_mid + $urandom_range(0, 6) - 3;
    px = book_mid;
    depth = BOOK_LEVELS;
    for (k = 0; k < n_items; k++) begin
      side = (k >= BOOK_LEVELS);
      lvl = k % BOOK_LEVELS;
      if (lvl == 0) begin
        px = side ? book_mid - $urandom_range(0, 2) : book_mid + $urandom_range(1, 3);
        depth = ($urandom_range(0, 3) == 0) ? $urandom_range(0, BOOK_LEVELS) : BOOK_LEVELS;
      end else begin
        px = side ? px - $urandom_range(1, 2) : px + $urandom_range(1, 2);
      end
      qty = (lvl < depth) ? book_qty() : 16'd0;
      send_level(side, 3'(lvl), px, qty, fr, k == 2*BOOK_LEVELS - 1);
    end
  endtask

  task automatic send_noise_level();
    logic [15:0] qty;
    qty = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom_range(0, 65535));
    send_level(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)), $urandom, qty,
               $urandom_range(0, 7) == 0, $urandom_range(0, 5) == 0);
  endtask

  // Every stored entry is written here, so no later merge reads an unwritten level.
  task automatic test_session_start();
    int k;
    for (k = 0; k < BOOK_LEVELS; k++)
      send_level(ASK, 3'(k), 32'(100 + k), 16'(10 + k), 1'b1, 1'b0);
    for (k = 0; k < BOOK_LEVELS; k++)
      send_level(BID, 3'(k), 32'(99 - k), 16'(20 + k), 1'b1, k == BOOK_LEVELS - 1);
    wait_drain(60);
  endtask

  task automatic test_extreme_prices();
    send_level(ASK, 0, PRICE_MAX, 16'hFFFF, 1'b0, 1'b0);
    send_level(ASK, 1, 0, 16'd0, 1'b0, 1'b0);
    send_level(BID, 0, PRICE_MIN, 16'hFFFF, 1'b0, 1'b0);
    send_level(BID, 1, 0, 16'd0, 1'b0, 1'b1);
    send_level(ASK, 0, PRICE_MIN, 16'd1, 1'b0, 1'b0);
    send_level(ASK, 1, PRICE_MAX, 16'd1, 1'b0, 1'b0);
    send_level(ASK, 2, 5, 16'd5, 1'b0, 1'b0);
    send_level(BID, 0, PRICE_MAX, 16'd1, 1'b0, 1'b0);
    send_level(BID, 1, PRICE_MIN, 16'hFFFF, 1'b0, 1'b0);
    send_level(BID, 2, 0, 16'd0, 1'b0, 1'b0);
    send_level(BID, 7, -5, 16'd3, 1'b1, 1'b1);
    wait_drain(60);
  endtask

  task automatic test_count_changes();
    send_level(ASK, 0, PRICE_MIN, 16'd2, 1'b0, 1'b0);
    send_level(ASK, 1, 0, 16'd3, 1'b0, 1'b0);
    send_level(ASK, 2, PRICE_MAX, 16'd1, 1'b0, 1'b0);
    send_level(ASK, 3, 6, 16'd2, 1'b0, 1'b0);
    send_level(ASK, 4, 103, 16'd4, 1'b0, 1'b0);
    send_level(ASK, 5, 0, 16'd0, 1'b0, 1'b0);
    send_level(BID, 0, PRICE_MAX, 16'd70, 1'b0, 1'b0);
    send_level(BID, 1, 0, 16'd0, 1'b0, 1'b0);
    send_level(BID, 3, 9, 16'd9, 1'b0, 1'b1);
    wait_drain(60);
  endtask

  task automatic test_random_book_traffic();
    int target;
    int pick;
    target = items_sent + 80;
    while (items_sent < target) begin
      pick = $urandom_range(0, 9);
      if ($urandom_range(0, 4) == 0) begin
        send_idle_odds = 0;
        recv_idle_odds = 0;
      end else begin
        send_idle_odds = 4;
        recv_idle_odds = 4;
      end
      if (pick < 7) begin
        send_book_row($urandom_range(0, 9) == 0, 2*BOOK_LEVELS);
      end else if (pick == 7) begin
        send_book_row(1'b0, $urandom_range(3, 12));
      end else begin
        repeat (4) send_noise_level();
      end
      if ($urandom_range(0, 7) == 0) book_mid = $urandom;
    end
    wait_drain(60);
  endtask

  task automatic test_output_hold();
    send_idle_odds = 0;
    recv_idle_odds = 4;
    hold_request = 300;
    send_book_row(1'b0, 2*BOOK_LEVELS);
    send_book_row(1'b0, 2*BOOK_LEVELS);
    wait_drain(60);
  endtask

  task automatic test_quiet_tail();
    send_idle_odds = 0;
    recv_idle_odds = 0;
    send_book_row(1'b0, 2*BOOK_LEVELS);
    send_book_row(1'b0, 2*BOOK_LEVELS);
    wait_drain(60);
  endtask

  initial begin
    foreach (prev_qty[k]) begin
      prev_px[k] = '0;
      prev_qty[k] = '0;
      cur_px[k] = '0;
      cur_qty[k] = '0;
    end
    merge_cursor[0] = 0;
    merge_cursor[1] = 0;
    merge_done[0] = 1'b0;
    merge_done[1] = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_session_start();
    test_extreme_prices();
    test_count_changes();
    test_random_book_traffic();
    test_output_hold();
    test_quiet_tail();
    $display("Sent %0d levels over %0d rows; checked %0d event runs, %0d mismatches.",
             items_sent, rows_sent, results_seen, mismatches);
    $display("Included extreme prices, count changes, first rows, noise and %0d long hold(s).",
             long_holds);
    if (mismatches == 0) begin
      $display("order_book_level_diff_unit regression: pass");
    end else begin
      $display("order_book_level_diff_unit regression: fail");
    end
    $finish;
  end

endmodule
